@@ hw/rtl/indexed_list_insert_erase_assert.svh @@
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_ERASE_ASSERT_SVH
`define INDEXED_LIST_INSERT_ERASE_ASSERT_SVH

`ifndef SYNTH
`define ILIE_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("indexed list check failed");
`define ILIE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed list check failed");
`define ILIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("indexed list check failed");
`else
`define ILIE_ASSERT_ALWAYS(lbl, expr)
`define ILIE_ASSERT_IMPLY(lbl, ante, cons)
`define ILIE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/ilie_pkg.sv @@
// Types and constants shared by the indexed list block.
`default_nettype none

package ilie_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_OVERWRITE   = 3'd0,
        OP_INSERT      = 3'd1,
        OP_APPEND      = 3'd2,
        OP_REMOVE_LAST = 3'd3,
        OP_ERASE       = 3'd4,
        OP_READ        = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SHIFT_WR,
        S_RDWAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]         operation;
        logic [3:0]         position;
        logic signed [31:0] item_value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [4:0]         fill_count;
        logic [1:0]         status;
    } t_out_res;

endpackage

`default_nettype wire

@@ hw/rtl/ilie_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ilie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_insert_erase.sv @@
// Indexed list with overwrite, insert, append, remove last, erase and read.
//
//   channel   direction  payload            handshake
//   in        input      ilie_pkg::t_in_req  i_in_valid / o_in_stall
//   out       output     ilie_pkg::t_out_res o_out_valid / i_out_stall
//
// One request is handled at a time by a small sequencer around a single RAM port pair.
// Overwrite, append, remove last and flagged requests go straight to S_FINISH, read
// via S_RDWAIT. Insert and erase move entries one at a time, each read then written.
// Reset empties the list at once; the stored words keep whatever they held.
// A result waiting on a stalled output does not block the next request from entering.
`default_nettype none
`include "indexed_list_insert_erase_assert.svh"

module indexed_list_insert_erase (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ilie_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ilie_pkg::t_out_res o_out_res
);

    ilie_pkg::t_state   r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [ilie_pkg::IDX_W-1:0] r_pos, n_pos;
    logic [ilie_pkg::WORD_BITS-1:0] r_word, n_word;
    logic [ilie_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [ilie_pkg::CNT_W-1:0] r_count, n_count;
    logic [ilie_pkg::WORD_BITS-1:0] r_rd, n_rd;
    ilie_pkg::t_status  r_st, n_st;
    logic               r_out_valid, n_out_valid;
    ilie_pkg::t_out_res r_out_res, n_out_res;

    logic                           ram_we;
    logic [ilie_pkg::IDX_W-1:0]     ram_waddr;
    logic [ilie_pkg::WORD_BITS-1:0] ram_wdata;
    logic [ilie_pkg::IDX_W-1:0]     ram_raddr;
    logic [ilie_pkg::WORD_BITS-1:0] ram_rdata;

    logic [ilie_pkg::CNT_W-1:0] w_step;
    logic                       w_more;
    logic [ilie_pkg::CNT_W-1:0] w_pos_ext;
    logic                       w_empty;
    logic                       w_full;
    logic                       w_bad;
    ilie_pkg::t_status          w_bad_st;
    logic                       load;

    ilie_ram #(
        .WIDTH(ilie_pkg::WORD_BITS),
        .DEPTH(ilie_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // The one shared index unit: a step up or down and a compare that ends the shift.
    assign w_step = (r_op == ilie_pkg::OP_INSERT) ? r_idx - ilie_pkg::CNT_W'(1)
                                                  : r_idx + ilie_pkg::CNT_W'(1);
    assign w_more = (r_op == ilie_pkg::OP_INSERT) ? (r_idx > ilie_pkg::CNT_W'(r_pos))
                                                  : (w_step < r_count);

    assign w_pos_ext = ilie_pkg::CNT_W'(i_in_req.position);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= ilie_pkg::CNT_W'(ilie_pkg::DEPTH));
    assign w_bad     = w_empty || (w_pos_ext >= r_count);
    assign w_bad_st  = w_empty ? ilie_pkg::ST_EMPTY : ilie_pkg::ST_RANGE;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pos     = r_pos;
        n_word    = r_word;
        n_idx     = r_idx;
        n_count   = r_count;
        n_rd      = r_rd;
        n_st      = r_st;
        ram_we    = 1'b0;
        ram_waddr = r_idx[ilie_pkg::IDX_W-1:0];
        ram_wdata = r_word;
        ram_raddr = w_step[ilie_pkg::IDX_W-1:0];
        load      = 1'b0;

        unique case (r_state)
            ilie_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_req.operation;
                    n_pos   = i_in_req.position;
                    n_word  = i_in_req.item_value;
                    n_rd    = '0;
                    n_st    = ilie_pkg::ST_OK;
                    n_state = ilie_pkg::S_FINISH;
                    case (i_in_req.operation)
                        ilie_pkg::OP_OVERWRITE: begin
                            if (w_bad) begin
                                n_st = w_bad_st;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = i_in_req.position;
                                ram_wdata = i_in_req.item_value;
                            end
                        end
                        ilie_pkg::OP_INSERT: begin
                            if (w_pos_ext > r_count) begin
                                n_st = ilie_pkg::ST_RANGE;
                            end else if (w_full) begin
                                n_st = ilie_pkg::ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = ilie_pkg::S_SHIFT;
                            end
                        end
                        ilie_pkg::OP_APPEND: begin
                            if (w_full) begin
                                n_st = ilie_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ilie_pkg::IDX_W-1:0];
                                ram_wdata = i_in_req.item_value;
                                n_count   = r_count + ilie_pkg::CNT_W'(1);
                            end
                        end
                        ilie_pkg::OP_REMOVE_LAST: begin
                            if (w_empty) begin
                                n_st = ilie_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - ilie_pkg::CNT_W'(1);
                            end
                        end
                        ilie_pkg::OP_ERASE: begin
                            if (w_bad) begin
                                n_st = w_bad_st;
                            end else begin
                                n_idx   = w_pos_ext;
                                n_state = ilie_pkg::S_SHIFT;
                            end
                        end
                        ilie_pkg::OP_READ: begin
                            if (w_bad) begin
                                n_st = w_bad_st;
                            end else begin
                                ram_raddr = i_in_req.position;
                                n_state   = ilie_pkg::S_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ilie_pkg::S_SHIFT: begin
                if (w_more) begin
                    n_state = ilie_pkg::S_SHIFT_WR;
                end else if (r_op == ilie_pkg::OP_INSERT) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = r_word;
                    n_count   = r_count + ilie_pkg::CNT_W'(1);
                    n_state   = ilie_pkg::S_FINISH;
                end else begin
                    n_count = r_count - ilie_pkg::CNT_W'(1);
                    n_state = ilie_pkg::S_FINISH;
                end
            end
            ilie_pkg::S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = w_step;
                n_state   = ilie_pkg::S_SHIFT;
            end
            ilie_pkg::S_RDWAIT: begin
                n_rd    = ram_rdata;
                n_state = ilie_pkg::S_FINISH;
            end
            ilie_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    load    = 1'b1;
                    n_state = ilie_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ilie_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = load || (r_out_valid && i_out_stall);
        n_out_res   = r_out_res;
        if (load) begin
            n_out_res.read_value = r_rd;
            n_out_res.fill_count = r_count;
            n_out_res.status     = r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilie_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_word    <= n_word;
        r_idx     <= n_idx;
        r_rd      <= n_rd;
        r_st      <= n_st;
        r_out_res <= n_out_res;
    end

    assign o_in_stall  = (r_state != ilie_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    `ILIE_ASSERT_ALWAYS(a_count_bound, r_count <= ilie_pkg::CNT_W'(ilie_pkg::DEPTH))
    `ILIE_ASSERT_IMPLY(a_shift_idx_bound, r_state == ilie_pkg::S_SHIFT, r_idx <= r_count)
    `ILIE_ASSERT_IMPLY(a_full_means_depth, o_out_valid && o_out_res.status == ilie_pkg::ST_FULL, o_out_res.fill_count == 5'(ilie_pkg::DEPTH))
    `ILIE_ASSERT_NEXT(a_count_step, 1'b1, r_count == $past(r_count) || r_count == $past(r_count) + ilie_pkg::CNT_W'(1) || r_count + ilie_pkg::CNT_W'(1) == $past(r_count))

endmodule

`default_nettype wire
